/* src/rrsf_pkg.sv */
// Package with the command codes, constants and stage types of the receive ring framer.
package rrsf_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    localparam logic [7:0] GAP_RESET = 8'd3;
    localparam logic [7:0] QUIET_MAX = 8'd255;
    localparam logic [8:0] LEN_MAX   = 9'd511;

    // Result fields that travel through the pipeline stage and the output register.
    typedef struct packed {
        logic       data_valid;
        logic       last_byte;
        logic       frame_ready;
        logic [8:0] frame_length;
        logic       overrun;
    } t_status;

endpackage

/* src/rx_ring_silence_framer.sv */
// Top level of the receive ring framer: ring memory, silence timer, read port and output stage.
//
// The block takes one command request per cycle on the s_axis channel and answers each one
// with exactly one result request on the m_axis channel, in order. s_axis_tuser carries the
// command (received byte, tick, read frame byte, release frame) and s_axis_tdata the received
// byte. Received bytes go into a ring memory of RING_DEPTH bytes; ticks time the silence after
// the last byte, and once gap_ticks quiet ticks have passed the frame is marked ready. Read
// commands pop the frame one byte per request, with tlast on the byte that ends the frame.
// Throughput is one request per cycle while m_axis_tready is high: every command is decided
// in the cycle it is accepted, and a popped byte comes from a single synchronous read of the
// ring memory. A result passes the memory read and stage register, then the output register,
// before it is visible on m_axis. When the receiver holds tready low, the output register
// and the stage behind it fill, and s_axis_tready drops only when both are full; no result
// is dropped or repeated. The gap_ticks register is to be written over the APB port only
// while the block is idle; the block does not enforce this. Reset clears the ring positions,
// the timer and the ready flag and loads gap_ticks with 3; the ring memory itself is not
// cleared and needs no sweep, since only bytes that were written can ever be popped.
module rx_ring_silence_framer #(
    parameter int RING_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [8] frame_ready,
                                        // [17:9] frame_length, [18] overrun, [23:19] zero
    output logic        m_axis_tlast,   // last_byte
    output logic        m_axis_tuser,   // [0] data_valid
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LW = (PW > 9) ? PW : 9;

    // Register address index of gap_ticks in the APB map.
    localparam logic REG_GAP = 1'b0;

    // Ring memory and its registered read data.
    logic [7:0]    r_ring [RING_DEPTH];
    logic [7:0]    r_rd_data;

    // Control state.
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_fe, n_fe;
    logic [PW-1:0] r_last, n_last;
    logic [7:0]    r_quiet, n_quiet;
    logic          r_recv, n_recv;
    logic          r_ready, n_ready;
    logic [7:0]    r_gap;

    // Pipeline stage and output register.
    logic                  r_s1_vld;
    rrsf_pkg::t_status     r_s1;
    rrsf_pkg::t_status     n_s1;
    logic                  r_out_vld;
    rrsf_pkg::t_status     r_out;
    logic [7:0]            r_out_data;

    rrsf_pkg::t_cmd s_cmd;
    logic           s_acc;
    logic           s1_move;
    logic           wr_en;
    logic           pop;
    logic           over;
    logic           last;
    logic [7:0]     quiet_inc;
    logic [PW:0]    diff_raw;
    logic [PW:0]    diff_mod;
    logic [LW-1:0]  diff_ext;
    logic [8:0]     len;

    function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] p);
        return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Handshake: the stage register takes a new request when it is empty or drains this cycle.
    assign s1_move       = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_move;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign s_cmd         = rrsf_pkg::t_cmd'(s_axis_tuser);

    assign quiet_inc = (r_quiet != rrsf_pkg::QUIET_MAX) ? r_quiet + 8'd1 : r_quiet;

    // Next control state for the accepted command.
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_fe    = r_fe;
        n_last  = r_last;
        n_quiet = r_quiet;
        n_recv  = r_recv;
        n_ready = r_ready;
        wr_en   = 1'b0;
        pop     = 1'b0;
        over    = 1'b0;
        last    = 1'b0;
        if (s_acc) begin
            unique case (s_cmd)
                rrsf_pkg::CMD_BYTE: begin
                    wr_en = 1'b1;
                    n_wp  = f_adv(r_wp);
                    over  = (f_adv(r_wp) == r_rp);
                    if (r_recv) begin
                        n_quiet = 8'd0;
                    end
                end
                rrsf_pkg::CMD_TICK: begin
                    if (!r_recv) begin
                        // Idle: start timing once unread bytes sit in the ring.
                        if (!r_ready && (r_wp != r_rp)) begin
                            n_recv  = 1'b1;
                            n_last  = r_wp;
                            n_quiet = 8'd0;
                        end
                    end else if (r_wp != r_last) begin
                        n_last  = r_wp;
                        n_quiet = 8'd0;
                    end else begin
                        n_quiet = quiet_inc;
                        if (quiet_inc >= r_gap) begin
                            n_fe    = r_wp;
                            n_ready = 1'b1;
                            n_recv  = 1'b0;
                        end
                    end
                end
                rrsf_pkg::CMD_READ: begin
                    if (r_ready) begin
                        if (r_rp == r_fe) begin
                            n_ready = 1'b0;
                        end else begin
                            pop  = 1'b1;
                            n_rp = f_adv(r_rp);
                            if (f_adv(r_rp) == r_fe) begin
                                last    = 1'b1;
                                n_ready = 1'b0;
                            end
                        end
                    end
                end
                rrsf_pkg::CMD_RELEASE: begin
                    n_ready = 1'b0;
                end
            endcase
        end
    end

    // Unread frame length after this request, taken modulo the ring depth and saturated.
    always_comb begin
        diff_raw = {1'b0, n_fe} - {1'b0, n_rp};
        diff_mod = diff_raw[PW] ? diff_raw + (PW + 1)'(RING_DEPTH) : diff_raw;
        diff_ext = LW'(diff_mod[PW-1:0]);
        if (!n_ready) begin
            len = 9'd0;
        end else if (diff_ext > LW'(rrsf_pkg::LEN_MAX)) begin
            len = rrsf_pkg::LEN_MAX;
        end else begin
            len = diff_ext[8:0];
        end
    end

    always_comb begin
        n_s1.data_valid   = pop;
        n_s1.last_byte    = last;
        n_s1.frame_ready  = n_ready;
        n_s1.frame_length = len;
        n_s1.overrun      = over;
    end

    // Ring memory: one write and one registered read per cycle, never at the same request.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[r_wp] <= s_axis_tdata;
        end
        if (pop) begin
            r_rd_data <= r_ring[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_fe    <= '0;
            r_last  <= '0;
            r_quiet <= 8'd0;
            r_recv  <= 1'b0;
            r_ready <= 1'b0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_fe    <= n_fe;
            r_last  <= n_last;
            r_quiet <= n_quiet;
            r_recv  <= n_recv;
            r_ready <= n_ready;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= rrsf_pkg::GAP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_GAP)) begin
            r_gap <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GAP) ? {24'd0, r_gap} : 32'd0;

    // Stage register and output register valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out      <= r_s1;
            r_out_data <= r_s1.data_valid ? r_rd_data : 8'd0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out.overrun, r_out.frame_length, r_out.frame_ready,
                            r_out_data};
    assign m_axis_tlast  = r_out.last_byte;
    assign m_axis_tuser  = r_out.data_valid;

    // The timer never runs while a finished frame waits.
    a_recv_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_recv && r_ready))
        else $error("timer running while a frame is ready");

    // A release always leaves the block without a ready frame.
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (s_cmd == rrsf_pkg::CMD_RELEASE)) |=> !r_ready)
        else $error("release did not clear frame ready");

    // Only a read request can pop a byte.
    a_pop_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (s_cmd != rrsf_pkg::CMD_READ)) |=> !r_s1.data_valid)
        else $error("byte popped by a request that is not a read");

    // Every received byte moves the write position.
    a_byte_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (s_cmd == rrsf_pkg::CMD_BYTE)) |=> (r_wp != $past(r_wp)))
        else $error("received byte did not advance the write position");

    // The last byte of a frame is always a popped byte and leaves no frame ready.
    a_last_is_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1.last_byte) |-> (r_s1.data_valid && !r_s1.frame_ready))
        else $error("last byte flagged without a pop or with frame still ready");

endmodule
